FILE: hdl/psa_pkg.sv
// Package: shared constants, types and control structs of the priority slot arbiter.
`default_nettype none

package psa_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int KIND_W    = 2;
  localparam int TOKEN_W   = 8;
  localparam int EXPR_W    = 6;
  localparam int PRIO_W    = 8;
  localparam int STAMP_W   = 32;
  localparam int GRANT_W   = 3;
  localparam int ES_W      = EXPR_W + STAMP_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_IDX_NEUTRAL = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_UPDATE  = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_SETTLE,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;      // capture input beat
    logic apply;     // execute the operation on the slot table
    logic scan_clr;  // reset scan pointer and best candidate
    logic scan_rd;   // read slot at scan pointer, advance
    logic commit;    // update winning code from best candidate
    logic emit;      // load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic apply_hit;  // operation takes effect, winner must be rescanned
    logic scan_last;  // scan pointer at last slot
    logic out_free;   // output register can take a new result
  } ctrl_status_t;

endpackage

`default_nettype wire

FILE: hdl/psa_in_if.sv
// Interface: input channel carrying one operation beat.
`default_nettype none

interface psa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  token;
  logic [5:0]  expression;
  logic [7:0]  priority_req;
  logic [31:0] now_ms;

  modport source (output valid, kind, token, expression, priority_req, now_ms, input ready);
  modport sink   (input valid, kind, token, expression, priority_req, now_ms, output ready);
endinterface

`default_nettype wire

FILE: hdl/psa_out_if.sv
// Interface: output channel carrying one result beat.
`default_nettype none

interface psa_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] granted_token;
  logic       grant_ok;
  logic       token_active;
  logic [5:0] current_expression;
  logic       expression_changed;

  modport source (output valid, granted_token, grant_ok, token_active, current_expression,
                  expression_changed, input ready);
  modport sink   (input valid, granted_token, grant_ok, token_active, current_expression,
                  expression_changed, output ready);
endinterface

`default_nettype wire

FILE: hdl/psa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]     wdata_i,
  input  wire                  re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/psa_ctrl.sv
// Controller FSM: sequences apply, winner scan, commit and result hand-off.
`default_nettype none

module psa_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire psa_pkg::ctrl_status_t status_i,
  output psa_pkg::ctrl_cmd_t     cmd_o
);
  import psa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply    = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = status_i.apply_hit ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        // last slot read lands and is compared this cycle
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_settle_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETTLE) |-> ($past(state_q) == ST_SCAN))
    else $error("settle not preceded by scan");
  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result emitted into a full output register");
  a_scan_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.apply && !status_i.apply_hit) |=> (state_q == ST_DONE))
    else $error("ineffective operation started a scan");
`endif

endmodule

`default_nettype wire

FILE: hdl/psa_dp.sv
// Datapath: slot table, free-slot search, winner scan and result register.
`default_nettype none

module psa_dp (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire psa_pkg::ctrl_cmd_t       cmd_i,
  output psa_pkg::ctrl_status_t         status_o,
  input  wire  [psa_pkg::EXPR_W-1:0]    neutral_i,
  input  wire  [psa_pkg::KIND_W-1:0]    kind_i,
  input  wire  [psa_pkg::TOKEN_W-1:0]   token_i,
  input  wire  [psa_pkg::EXPR_W-1:0]    expression_i,
  input  wire  [psa_pkg::PRIO_W-1:0]    priority_req_i,
  input  wire  [psa_pkg::STAMP_W-1:0]   now_ms_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [psa_pkg::GRANT_W-1:0]   granted_token_o,
  output logic                          grant_ok_o,
  output logic                          token_active_o,
  output logic [psa_pkg::EXPR_W-1:0]    current_expression_o,
  output logic                          expression_changed_o
);
  import psa_pkg::*;

  // captured item
  kind_e                kind_q;
  logic [TOKEN_W-1:0]   tok_q;
  logic [EXPR_W-1:0]    expr_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [STAMP_W-1:0]   now_q;
  logic [EXPR_W-1:0]    before_q;

  // slot table state
  logic [NUM_SLOTS-1:0] valid_q;
  logic [EXPR_W-1:0]    winner_q;

  // scan state
  logic [SLOT_IDX_W-1:0] scan_q;
  logic                  cmp_pend_q;
  logic [SLOT_IDX_W-1:0] cmp_idx_q;
  logic                  have_q;
  logic [PRIO_W-1:0]     best_prio_q;
  logic [STAMP_W-1:0]    best_stamp_q;
  logic [EXPR_W-1:0]     best_expr_q;

  // grant result of the apply step
  logic [GRANT_W-1:0]    granted_q;
  logic                  ok_q;

  logic                  out_valid_q;

  // combinational
  logic                  in_range;
  logic [SLOT_IDX_W-1:0] tok_idx;
  logic                  tok_valid;
  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [7:0]            free_ext;
  logic                  op_request;
  logic                  op_modify;
  logic                  hit;
  logic                  es_we;
  logic [SLOT_IDX_W-1:0] es_waddr;
  logic                  pr_we;
  logic [ES_W-1:0]       es_rdata;
  logic [PRIO_W-1:0]     pr_rdata;
  logic [EXPR_W-1:0]     rd_expr;
  logic [STAMP_W-1:0]    rd_stamp;
  logic                  better;

  assign in_range  = {1'b0, tok_q} < (TOKEN_W+1)'(NUM_SLOTS);
  assign tok_idx   = tok_q[SLOT_IDX_W-1:0];
  assign tok_valid = in_range && valid_q[tok_idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign free_ext   = 8'(free_idx);
  assign op_request = (kind_q == KIND_REQUEST) && free_found;
  assign op_modify  = ((kind_q == KIND_UPDATE) || (kind_q == KIND_RELEASE)) && tok_valid;
  assign hit        = op_request || op_modify;

  assign es_we    = cmd_i.apply && (op_request || ((kind_q == KIND_UPDATE) && tok_valid));
  assign es_waddr = op_request ? free_idx : tok_idx;
  assign pr_we    = cmd_i.apply && op_request;

  psa_ram #(.WIDTH(ES_W), .DEPTH(NUM_SLOTS)) u_es_ram (
    .clk_i   (clk_i),
    .we_i    (es_we),
    .waddr_i (es_waddr),
    .wdata_i ({expr_q, now_q}),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_q),
    .rdata_o (es_rdata)
  );

  psa_ram #(.WIDTH(PRIO_W), .DEPTH(NUM_SLOTS)) u_pr_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (free_idx),
    .wdata_i (prio_q),
    .re_i    (cmd_i.scan_rd),
    .raddr_i (scan_q),
    .rdata_o (pr_rdata)
  );

  assign rd_expr  = es_rdata[ES_W-1:STAMP_W];
  assign rd_stamp = es_rdata[STAMP_W-1:0];

  // strict compare keeps the lower index on a full tie
  assign better = cmp_pend_q && valid_q[cmp_idx_q] &&
                  (!have_q || (pr_rdata > best_prio_q) ||
                   ((pr_rdata == best_prio_q) && (rd_stamp > best_stamp_q)));

  // item capture and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_e'(kind_i);
      tok_q    <= token_i;
      expr_q   <= expression_i;
      prio_q   <= priority_req_i;
      now_q    <= now_ms_i;
      before_q <= winner_q;
    end
    if (cmd_i.apply) begin
      granted_q <= op_request ? free_ext[GRANT_W-1:0] : '0;
      ok_q      <= op_request;
    end
    cmp_idx_q <= scan_q;
    if (better) begin
      best_prio_q  <= pr_rdata;
      best_stamp_q <= rd_stamp;
      best_expr_q  <= rd_expr;
    end
    if (cmd_i.emit) begin
      granted_token_o      <= granted_q;
      grant_ok_o           <= ok_q;
      token_active_o       <= tok_valid;
      current_expression_o <= winner_q;
      expression_changed_o <= winner_q != before_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      winner_q    <= '0;
      scan_q      <= '0;
      cmp_pend_q  <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        if (op_request) begin
          valid_q[free_idx] <= 1'b1;
        end else if ((kind_q == KIND_RELEASE) && tok_valid) begin
          valid_q[tok_idx] <= 1'b0;
        end
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
        have_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_q <= scan_q + 1'b1;
        end
        if (better) begin
          have_q <= 1'b1;
        end
      end
      cmp_pend_q <= cmd_i.scan_rd;
      if (cmd_i.commit) begin
        winner_q <= have_q ? best_expr_q : neutral_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.apply_hit = hit;
  assign status_o.scan_last = scan_q == SLOT_IDX_W'(NUM_SLOTS - 1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

`ifndef ASSERT_OFF
  a_grant_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && op_request) |=> valid_q[$past(free_idx)])
    else $error("granted slot not marked active");
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && (kind_q == KIND_RELEASE) && tok_valid) |=> !valid_q[$past(tok_idx)])
    else $error("released slot still active");
  a_commit_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !cmp_pend_q)
    else $error("winner committed with a compare outstanding");
`endif

endmodule

`default_nettype wire

FILE: hdl/priority_slot_arbiter.sv
// Top level: priority slot arbiter with APB configuration and valid/ready channels.
//
// Usage:
//   req_i  : operation beats (request, update, release, query) on valid/ready.
//   rsp_o  : exactly one result beat per operation, in order.
//   APB    : register 0 (byte address 0) holds the neutral code, 6 bits, reset 0.
//            It is picked up the next time the winner is rescanned.
// Sequencing / throughput:
//   An effective request, update or release rescans the slot table, one slot per
//   cycle out of the slot RAMs, then settles, commits the winner and emits a result.
//   A query or an ignored operation skips the scan and goes from apply to done.
//   One operation is in flight at a time; the scan through the slot RAM read
//   port sets the rate. req_i.ready is high in the idle state.
// Reset:
//   All slots inactive, winning code and neutral code 0, no result pending.
//   Slot contents are not cleared; only active slots are ever compared.
// Back-pressure:
//   A result sits in the output register until rsp_o.ready; the next beat is
//   accepted meanwhile, and its result waits in the done state until the
//   output register frees up.
`default_nettype none

module priority_slot_arbiter (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  psa_in_if.sink                            req_i,
  psa_out_if.source                         rsp_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [psa_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [psa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [psa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import psa_pkg::*;

  ctrl_cmd_t        cmd;
  ctrl_status_t     status;
  logic             in_ready;
  logic [EXPR_W-1:0] neutral_q;
  logic             reg_sel;

  // APB register file: only the neutral code lives here
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_IDX_NEUTRAL) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      neutral_q <= pwdata[EXPR_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(neutral_q) : '0;

  assign req_i.ready = in_ready;

  psa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psa_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .neutral_i            (neutral_q),
    .kind_i               (req_i.kind),
    .token_i              (req_i.token),
    .expression_i         (req_i.expression),
    .priority_req_i       (req_i.priority_req),
    .now_ms_i             (req_i.now_ms),
    .out_valid_o          (rsp_o.valid),
    .out_ready_i          (rsp_o.ready),
    .granted_token_o      (rsp_o.granted_token),
    .grant_ok_o           (rsp_o.grant_ok),
    .token_active_o       (rsp_o.token_active),
    .current_expression_o (rsp_o.current_expression),
    .expression_changed_o (rsp_o.expression_changed)
  );

endmodule

`default_nettype wire
